FILE: hdl/psc_pkg.sv
// Shared constants and helpers for the pressure sensor compensation pipeline.
// Depends on nothing; imported by pressure_sensor_compensation and the bench.
`timescale 1ns / 1ps
`default_nettype none

package psc_pkg;

    // Number of register stages from the input beat to the output register.
    localparam int NUM_STAGES = 11;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_C1    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_C2    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_C3    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_C4    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_C5    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_C6    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_MODEL = 3'd6;

    // Field widths.
    localparam int COEF_W = 16;
    localparam int RAW_W  = 24;
    localparam int OUT_W  = 32;

    // Scaling shifts, 2 bar model.
    localparam logic [6:0] SENS_SH_2BA  = 7'd16;
    localparam logic [6:0] OFF_SH_2BA   = 7'd17;
    localparam logic [6:0] SENSD_SH_2BA = 7'd7;
    localparam logic [6:0] OFFD_SH_2BA  = 7'd6;
    localparam logic [6:0] PRES_SH_2BA  = 7'd15;

    // Scaling shifts, 30 bar model.
    localparam logic [6:0] SENS_SH_30BA  = 7'd15;
    localparam logic [6:0] OFF_SH_30BA   = 7'd16;
    localparam logic [6:0] SENSD_SH_30BA = 7'd8;
    localparam logic [6:0] OFFD_SH_30BA  = 7'd7;
    localparam logic [6:0] PRES_SH_30BA  = 7'd13;

    // Shifts shared by both models.
    localparam logic [6:0] TEMP_SH = 7'd23;
    localparam logic [6:0] PROD_SH = 7'd21;

    // Temperature reference points, in hundredths of a degree.
    localparam int TEMP_REF     = 2000;
    // Very-low band: TEMP <= -1600, i.e. deviation from TEMP_REF <= -3600.
    localparam int VLOW_DEV_MAX = -3600;
    // TEMP + 1500 expressed on the deviation from TEMP_REF.
    localparam int VLOW_BASE    = 3500;

    // Signed division by a power of two, truncating toward zero.
    function automatic logic signed [71:0] div_pow2_trunc(
        input logic signed [71:0] x,
        input logic [6:0]         sh
    );
        logic signed [71:0] bias;
        bias = x[71] ? ((72'sd1 <<< sh) - 72'sd1) : 72'sd0;
        return (x + bias) >>> sh;
    endfunction

endpackage

`default_nettype wire

FILE: hdl/pressure_sensor_compensation.sv
// Top level of the second-order pressure and temperature compensation pipeline.
// Depends on psc_pkg for register indexes, scaling shifts and the divide helper.
`timescale 1ns / 1ps
`default_nettype none

// The block takes one beat of raw pressure and raw temperature per clock and
// returns the compensated pressure and temperature, one beat per cycle while
// the output is not held. The eleven register stages are: temperature
// difference, three calibration products, first-order gain/offset/temperature,
// three squares, the correction terms, corrected gain/offset/temperature, the
// split 24 by 41 bit pressure product, its recombination, the truncating
// scale of the product, the offset subtraction, and the final truncating
// pressure scale into the output register. Any stage that holds no beat takes
// a new one even while the output waits, so bubbles close up under
// backpressure. Calibration words and the model select must be written while
// no beat is in flight; they are read directly by several stages.
module pressure_sensor_compensation (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    // Configuration write port
    input  wire logic                           cfg_wr_en,
    input  wire logic [psc_pkg::CFG_IDX_W-1:0]  cfg_wr_index,
    input  wire logic [psc_pkg::COEF_W-1:0]     cfg_wr_data,
    // Input stream
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // [23:0] raw_pressure, [47:24] raw_temperature
    input  wire logic [2*psc_pkg::RAW_W-1:0]    s_tdata,
    // Result stream
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // [31:0] pressure_out, [63:32] temperature_out
    output logic [2*psc_pkg::OUT_W-1:0]         m_tdata
);

    import psc_pkg::*;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [COEF_W-1:0] coef_c1_reg, coef_c2_reg, coef_c3_reg;
    logic [COEF_W-1:0] coef_c4_reg, coef_c5_reg, coef_c6_reg;
    logic              model_02ba_reg;

    // A write to an index past the model select is dropped.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coef_c1_reg    <= '0;
            coef_c2_reg    <= '0;
            coef_c3_reg    <= '0;
            coef_c4_reg    <= '0;
            coef_c5_reg    <= '0;
            coef_c6_reg    <= '0;
            model_02ba_reg <= 1'b0;
        end else if (cfg_wr_en) begin
            case (cfg_wr_index)
                CFG_IDX_C1:    coef_c1_reg    <= cfg_wr_data;
                CFG_IDX_C2:    coef_c2_reg    <= cfg_wr_data;
                CFG_IDX_C3:    coef_c3_reg    <= cfg_wr_data;
                CFG_IDX_C4:    coef_c4_reg    <= cfg_wr_data;
                CFG_IDX_C5:    coef_c5_reg    <= cfg_wr_data;
                CFG_IDX_C6:    coef_c6_reg    <= cfg_wr_data;
                CFG_IDX_MODEL: model_02ba_reg <= cfg_wr_data[0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pipeline control: a stage loads when it is empty or its beat moves on
    // ------------------------------------------------------------------
    logic [NUM_STAGES:1] valid_reg;
    logic [NUM_STAGES:1] valid_next;
    logic [NUM_STAGES:1] stage_en;
    logic [NUM_STAGES:1] valid_in;

    always_comb begin
        stage_en[NUM_STAGES] = !valid_reg[NUM_STAGES] || m_tready;
        for (int i = NUM_STAGES - 1; i >= 1; i--) begin
            stage_en[i] = !valid_reg[i] || stage_en[i+1];
        end
        valid_in = {valid_reg[NUM_STAGES-1:1], s_tvalid};
        for (int i = 1; i <= NUM_STAGES; i++) begin
            valid_next[i] = stage_en[i] ? valid_in[i] : valid_reg[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    assign s_tready = stage_en[1];
    assign m_tvalid = valid_reg[NUM_STAGES];

    logic two_bar;
    assign two_bar = model_02ba_reg;

    // ------------------------------------------------------------------
    // Stage 1: temperature difference dT = D2 - C5 * 256
    // ------------------------------------------------------------------
    logic        [RAW_W-1:0] d1_s1_reg, d1_s1_next;
    logic signed [24:0]      td_s1_reg, td_s1_next;

    assign d1_s1_next = s_tdata[RAW_W-1:0];
    assign td_s1_next = $signed({1'b0, s_tdata[2*RAW_W-1:RAW_W]})
                      - $signed({1'b0, coef_c5_reg, 8'b0});

    // ------------------------------------------------------------------
    // Stage 2: calibration products C3*dT, C4*dT, C6*dT
    // ------------------------------------------------------------------
    logic        [RAW_W-1:0] d1_s2_reg;
    logic signed [24:0]      td_s2_reg;
    logic signed [41:0]      p3_s2_reg, p3_s2_next;
    logic signed [41:0]      p4_s2_reg, p4_s2_next;
    logic signed [41:0]      p6_s2_reg, p6_s2_next;

    assign p3_s2_next = $signed({1'b0, coef_c3_reg}) * td_s1_reg;
    assign p4_s2_next = $signed({1'b0, coef_c4_reg}) * td_s1_reg;
    assign p6_s2_next = $signed({1'b0, coef_c6_reg}) * td_s1_reg;

    // ------------------------------------------------------------------
    // Stage 3: first-order sensitivity, offset and temperature deviation
    // ------------------------------------------------------------------
    logic        [RAW_W-1:0] d1_s3_reg;
    logic signed [24:0]      td_s3_reg;
    logic signed [35:0]      gain_s3_reg, gain_s3_next;
    logic signed [36:0]      off_s3_reg, off_s3_next;
    logic signed [17:0]      tq_s3_reg, tq_s3_next;
    logic signed [71:0]      gain_full, off_full;

    always_comb begin
        gain_full = div_pow2_trunc(72'(p3_s2_reg), two_bar ? SENSD_SH_2BA : SENSD_SH_30BA)
                  + $signed(72'(coef_c1_reg) << (two_bar ? SENS_SH_2BA : SENS_SH_30BA));
        off_full  = div_pow2_trunc(72'(p4_s2_reg), two_bar ? OFFD_SH_2BA : OFFD_SH_30BA)
                  + $signed(72'(coef_c2_reg) << (two_bar ? OFF_SH_2BA : OFF_SH_30BA));
        gain_s3_next = 36'(gain_full);
        off_s3_next  = 37'(off_full);
        // TEMP - 2000, the deviation from the reference point.
        tq_s3_next   = 18'(div_pow2_trunc(72'(p6_s2_reg), TEMP_SH));
    end

    // ------------------------------------------------------------------
    // Stage 4: squares of the deviation, of dT and of TEMP + 1500
    // ------------------------------------------------------------------
    logic        [RAW_W-1:0] d1_s4_reg;
    logic signed [35:0]      gain_s4_reg;
    logic signed [36:0]      off_s4_reg;
    logic signed [17:0]      tq_s4_reg;
    logic        [33:0]      dev_s4_reg, dev_s4_next;
    logic        [47:0]      tsq_s4_reg, tsq_s4_next;
    logic        [35:0]      vl_s4_reg, vl_s4_next;
    logic                    low_s4_reg, low_s4_next;
    logic                    vlow_s4_reg, vlow_s4_next;
    logic signed [35:0]      tq_sq;
    logic signed [49:0]      td_sq;
    logic signed [18:0]      vl_base;
    logic signed [37:0]      vl_sq;

    always_comb begin
        tq_sq        = tq_s3_reg * tq_s3_reg;
        td_sq        = td_s3_reg * td_s3_reg;
        vl_base      = 19'(tq_s3_reg) + 19'(VLOW_BASE);
        vl_sq        = vl_base * vl_base;
        dev_s4_next  = tq_sq[33:0];
        tsq_s4_next  = td_sq[47:0];
        vl_s4_next   = vl_sq[35:0];
        low_s4_next  = tq_s3_reg[17];
        vlow_s4_next = (tq_s3_reg <= 18'(VLOW_DEV_MAX));
    end

    // ------------------------------------------------------------------
    // Stage 5: second-order correction terms (all non-negative)
    // ------------------------------------------------------------------
    logic        [RAW_W-1:0] d1_s5_reg;
    logic signed [35:0]      gain_s5_reg;
    logic signed [36:0]      off_s5_reg;
    logic signed [17:0]      tq_s5_reg;
    logic        [16:0]      tcor_s5_reg, tcor_s5_next;
    logic        [39:0]      ocor_s5_reg, ocor_s5_next;
    logic        [38:0]      gcor_s5_reg, gcor_s5_next;
    logic        [51:0]      tsq_x11;
    logic        [49:0]      tsq_x3;
    logic        [38:0]      dev_x31;
    logic        [39:0]      dev_x63;
    logic        [35:0]      dev_x3;
    logic        [36:0]      dev_x5;
    logic        [38:0]      vl_x7;
    logic        [37:0]      vl_x4;

    always_comb begin
        tsq_x11 = {tsq_s4_reg, 3'b0} + {tsq_s4_reg, 1'b0} + 52'(tsq_s4_reg);
        tsq_x3  = {tsq_s4_reg, 1'b0} + 50'(tsq_s4_reg);
        dev_x31 = {dev_s4_reg, 5'b0} - 39'(dev_s4_reg);
        dev_x63 = {dev_s4_reg, 6'b0} - 40'(dev_s4_reg);
        dev_x3  = {dev_s4_reg, 1'b0} + 36'(dev_s4_reg);
        dev_x5  = {dev_s4_reg, 2'b0} + 37'(dev_s4_reg);
        vl_x7   = {vl_s4_reg, 3'b0} - 39'(vl_s4_reg);
        vl_x4   = {vl_s4_reg, 2'b0};

        tcor_s5_next = '0;
        ocor_s5_next = '0;
        gcor_s5_next = '0;
        if (two_bar) begin
            // 2 bar model corrects only below the reference temperature.
            if (low_s4_reg) begin
                tcor_s5_next = tsq_x11[51:35];
                ocor_s5_next = 40'(dev_x31[38:3]);
                gcor_s5_next = 39'(dev_x63[39:5]);
            end
        end else if (low_s4_reg) begin
            tcor_s5_next = tsq_x3[49:33];
            ocor_s5_next = 40'(dev_x3[35:1]) + (vlow_s4_reg ? 40'(vl_x7) : 40'd0);
            gcor_s5_next = 39'(dev_x5[36:3]) + (vlow_s4_reg ? 39'(vl_x4) : 39'd0);
        end else begin
            // 30 bar high temperature: 2*dT^2/2^37 and deviation^2/16.
            tcor_s5_next = 17'(tsq_s4_reg[47:36]);
            ocor_s5_next = 40'(dev_s4_reg[33:4]);
        end
    end

    // ------------------------------------------------------------------
    // Stage 6: corrected sensitivity, offset and final temperature
    // ------------------------------------------------------------------
    logic        [RAW_W-1:0] d1_s6_reg;
    logic signed [40:0]      gain2_s6_reg, gain2_s6_next;
    logic signed [41:0]      off2_s6_reg, off2_s6_next;
    logic signed [OUT_W-1:0] temp_s6_reg, temp_s6_next;

    assign gain2_s6_next = 41'(gain_s5_reg) - $signed({2'b0, gcor_s5_reg});
    assign off2_s6_next  = 42'(off_s5_reg) - $signed({2'b0, ocor_s5_reg});
    assign temp_s6_next  = 32'(tq_s5_reg) + 32'(TEMP_REF) - $signed({15'b0, tcor_s5_reg});

    // ------------------------------------------------------------------
    // Stage 7: D1 * SENS2 as two partial products on a 20-bit split
    // ------------------------------------------------------------------
    logic        [43:0]      pl_s7_reg, pl_s7_next;
    logic signed [44:0]      ph_s7_reg, ph_s7_next;
    logic signed [41:0]      off2_s7_reg;
    logic signed [OUT_W-1:0] temp_s7_reg;
    logic signed [20:0]      gain2_hi;

    assign gain2_hi   = gain2_s6_reg[40:20];
    assign pl_s7_next = d1_s6_reg * gain2_s6_reg[19:0];
    assign ph_s7_next = $signed({1'b0, d1_s6_reg}) * gain2_hi;

    // ------------------------------------------------------------------
    // Stage 8: recombine the partial products
    // ------------------------------------------------------------------
    logic signed [64:0]      prod_s8_reg, prod_s8_next;
    logic signed [41:0]      off2_s8_reg;
    logic signed [OUT_W-1:0] temp_s8_reg;

    assign prod_s8_next = $signed({ph_s7_reg, 20'b0}) + $signed({21'b0, pl_s7_reg});

    // ------------------------------------------------------------------
    // Stage 9: product / 2^21
    // ------------------------------------------------------------------
    logic signed [43:0]      q_s9_reg, q_s9_next;
    logic signed [41:0]      off2_s9_reg;
    logic signed [OUT_W-1:0] temp_s9_reg;

    assign q_s9_next = 44'(div_pow2_trunc(72'(prod_s8_reg), PROD_SH));

    // ------------------------------------------------------------------
    // Stage 10: subtract the corrected offset
    // ------------------------------------------------------------------
    logic signed [44:0]      diff_s10_reg, diff_s10_next;
    logic signed [OUT_W-1:0] temp_s10_reg;

    assign diff_s10_next = 45'(q_s9_reg) - 45'(off2_s9_reg);

    // ------------------------------------------------------------------
    // Stage 11: final pressure scale into the output register
    // ------------------------------------------------------------------
    logic signed [OUT_W-1:0] pres_s11_reg, pres_s11_next;
    logic signed [OUT_W-1:0] temp_s11_reg;

    assign pres_s11_next = 32'(div_pow2_trunc(72'(diff_s10_reg),
                                              two_bar ? PRES_SH_2BA : PRES_SH_30BA));

    assign m_tdata = {temp_s11_reg, pres_s11_reg};

    // ------------------------------------------------------------------
    // Payload registers, each loaded when its stage is enabled
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (stage_en[1]) begin
            d1_s1_reg <= d1_s1_next;
            td_s1_reg <= td_s1_next;
        end
        if (stage_en[2]) begin
            d1_s2_reg <= d1_s1_reg;
            td_s2_reg <= td_s1_reg;
            p3_s2_reg <= p3_s2_next;
            p4_s2_reg <= p4_s2_next;
            p6_s2_reg <= p6_s2_next;
        end
        if (stage_en[3]) begin
            d1_s3_reg   <= d1_s2_reg;
            td_s3_reg   <= td_s2_reg;
            gain_s3_reg <= gain_s3_next;
            off_s3_reg  <= off_s3_next;
            tq_s3_reg   <= tq_s3_next;
        end
        if (stage_en[4]) begin
            d1_s4_reg   <= d1_s3_reg;
            gain_s4_reg <= gain_s3_reg;
            off_s4_reg  <= off_s3_reg;
            tq_s4_reg   <= tq_s3_reg;
            dev_s4_reg  <= dev_s4_next;
            tsq_s4_reg  <= tsq_s4_next;
            vl_s4_reg   <= vl_s4_next;
            low_s4_reg  <= low_s4_next;
            vlow_s4_reg <= vlow_s4_next;
        end
        if (stage_en[5]) begin
            d1_s5_reg   <= d1_s4_reg;
            gain_s5_reg <= gain_s4_reg;
            off_s5_reg  <= off_s4_reg;
            tq_s5_reg   <= tq_s4_reg;
            tcor_s5_reg <= tcor_s5_next;
            ocor_s5_reg <= ocor_s5_next;
            gcor_s5_reg <= gcor_s5_next;
        end
        if (stage_en[6]) begin
            d1_s6_reg    <= d1_s5_reg;
            gain2_s6_reg <= gain2_s6_next;
            off2_s6_reg  <= off2_s6_next;
            temp_s6_reg  <= temp_s6_next;
        end
        if (stage_en[7]) begin
            pl_s7_reg   <= pl_s7_next;
            ph_s7_reg   <= ph_s7_next;
            off2_s7_reg <= off2_s6_reg;
            temp_s7_reg <= temp_s6_reg;
        end
        if (stage_en[8]) begin
            prod_s8_reg <= prod_s8_next;
            off2_s8_reg <= off2_s7_reg;
            temp_s8_reg <= temp_s7_reg;
        end
        if (stage_en[9]) begin
            q_s9_reg    <= q_s9_next;
            off2_s9_reg <= off2_s8_reg;
            temp_s9_reg <= temp_s8_reg;
        end
        if (stage_en[10]) begin
            diff_s10_reg <= diff_s10_next;
            temp_s10_reg <= temp_s9_reg;
        end
        if (stage_en[NUM_STAGES]) begin
            pres_s11_reg <= pres_s11_next;
            temp_s11_reg <= temp_s10_reg;
        end
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------

    // A beat taken in with none leaving adds exactly one occupied stage.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && !(m_tvalid && m_tready))
        |=> ($countones(valid_reg) == $past($countones(valid_reg)) + 1))
        else $error("pipeline occupancy did not grow by one on an accepted beat");

    // Input backpressure only when every stage holds a beat.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (&valid_reg))
        else $error("input stalled while a pipeline stage was empty");

    // The 2 bar model applies no correction at or above the reference point.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (valid_reg[4] && stage_en[5] && two_bar && !low_s4_reg)
        |=> (tcor_s5_reg == '0 && ocor_s5_reg == '0 && gcor_s5_reg == '0))
        else $error("2 bar high temperature produced a nonzero correction");

endmodule

`default_nettype wire

FILE: bench/tb.sv
// Self-checking bench for the pressure and temperature compensation pipeline.
// Depends on psc_pkg and pressure_sensor_compensation; predicts each reading in 64-bit math.
`timescale 1ns / 1ps

module tb;
    import psc_pkg::*;

    localparam int RESET_CYCLES = 5;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int HOLD_CYCLES  = 200;
    localparam int MAX_REPORTS  = 10;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED = 3'd7;

    // Compensation breakpoints, in hundredths of a degree.
    localparam longint VERY_LOW_LIMIT = -1600;
    localparam longint VERY_LOW_BASE  = 1500;

    localparam logic [RAW_W-1:0] RAW_MAX = 24'hFFFFFF;

    typedef struct {
        logic signed [OUT_W-1:0] pressure;
        logic signed [OUT_W-1:0] temperature;
    } reading_t;

    logic                   aclk;
    logic                   aresetn      = 1'b0;
    logic                   cfg_wr_en    = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_wr_index = '0;
    logic [COEF_W-1:0]      cfg_wr_data  = '0;
    logic                   s_tvalid     = 1'b0;
    logic                   s_tready;
    logic [2*RAW_W-1:0]     s_tdata      = '0;
    logic                   m_tvalid;
    logic                   m_tready     = 1'b0;
    logic [2*OUT_W-1:0]     m_tdata;

    // When set, both sides run without idle cycles.
    bit steady       = 1'b0;
    // Asks the receiver process for one long hold-off.
    bit hold_request = 1'b0;

    pressure_sensor_compensation dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata)
    );

    // Keeps its own copy of the calibration words, computes the compensated
    // reading of every accepted sample pair and checks the output beats in order.
    class compensation_model;
        logic [COEF_W-1:0] cal [6];
        bit                two_bar;
        reading_t          expected_q [$];
        int                mismatches;

        function new();
            foreach (cal[i]) cal[i] = '0;
            two_bar    = 1'b0;
            mismatches = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [COEF_W-1:0] val);
            if (idx <= CFG_IDX_C6)
                cal[idx - CFG_IDX_C1] = val;
            else if (idx == CFG_IDX_MODEL)
                two_bar = val[0];
        endfunction

        function void note_sample(logic [RAW_W-1:0] d1_raw, logic [RAW_W-1:0] d2_raw);
            longint d1, d2, c1, c2, c3, c4, c5, c6;
            longint dt, sens, off, t_first, dev_sq, vlow_sq;
            longint t_low, off_low, sens_low, p_comp, t_comp;
            reading_t r;
            d1 = longint'({40'd0, d1_raw});
            d2 = longint'({40'd0, d2_raw});
            c1 = longint'({48'd0, cal[0]});
            c2 = longint'({48'd0, cal[1]});
            c3 = longint'({48'd0, cal[2]});
            c4 = longint'({48'd0, cal[3]});
            c5 = longint'({48'd0, cal[4]});
            c6 = longint'({48'd0, cal[5]});
            t_low    = 0;
            off_low  = 0;
            sens_low = 0;

            // First order terms.
            dt = d2 - c5 * 256;
            if (two_bar) begin
                sens = c1 * 65536 + (c3 * dt) / 128;
                off  = c2 * 131072 + (c4 * dt) / 64;
            end else begin
                sens = c1 * 32768 + (c3 * dt) / 256;
                off  = c2 * 65536 + (c4 * dt) / 128;
            end
            t_first = TEMP_REF + (dt * c6) / 8388608;
            dev_sq  = (t_first - TEMP_REF) * (t_first - TEMP_REF);

            // Second order corrections by temperature band.
            if (two_bar) begin
                if (t_first < TEMP_REF) begin
                    t_low    = (11 * (dt * dt)) / 64'sd34359738368;
                    off_low  = (31 * dev_sq) / 8;
                    sens_low = (63 * dev_sq) / 32;
                end
            end else if (t_first < TEMP_REF) begin
                t_low    = (3 * (dt * dt)) / 64'sd8589934592;
                off_low  = (3 * dev_sq) / 2;
                sens_low = (5 * dev_sq) / 8;
                if (t_first <= VERY_LOW_LIMIT) begin
                    vlow_sq  = (t_first + VERY_LOW_BASE) * (t_first + VERY_LOW_BASE);
                    off_low  = off_low + 7 * vlow_sq;
                    sens_low = sens_low + 4 * vlow_sq;
                end
            end else begin
                t_low   = (2 * (dt * dt)) / 64'sd137438953472;
                off_low = dev_sq / 16;
            end

            off    = off - off_low;
            sens   = sens - sens_low;
            t_comp = t_first - t_low;
            if (two_bar)
                p_comp = ((d1 * sens) / 2097152 - off) / 32768;
            else
                p_comp = ((d1 * sens) / 2097152 - off) / 8192;

            r.pressure    = p_comp[OUT_W-1:0];
            r.temperature = t_comp[OUT_W-1:0];
            expected_q.push_back(r);
        endfunction

        function void flag(string what, logic [OUT_W-1:0] exp_v, logic [OUT_W-1:0] act_v);
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("mismatch in %s: expected %0d (0x%08h), got %0d (0x%08h)",
                         what, $signed(exp_v), exp_v, $signed(act_v), act_v);
        endfunction

        function void check_reading(logic [2*OUT_W-1:0] data);
            reading_t r;
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("output beat 0x%016h arrived with no reading pending", data);
            end else begin
                r = expected_q.pop_front();
                if (data[OUT_W-1:0] !== r.pressure)
                    flag("pressure", r.pressure, data[OUT_W-1:0]);
                if (data[2*OUT_W-1:OUT_W] !== r.temperature)
                    flag("temperature", r.temperature, data[2*OUT_W-1:OUT_W]);
            end
        endfunction
    endclass

    compensation_model comp = new();

    // Clock.
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Output beats are checked against the oldest pending reading.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            comp.check_reading(m_tdata);
    end

    // Receiver: short random stalls, a few long ones, and one long hold-off on request.
    initial begin
        int stall_left;
        int r;
        stall_left = 0;
        forever begin
            @(posedge aclk);
            if (hold_request) begin
                hold_request = 1'b0;
                stall_left   = HOLD_CYCLES;
            end
            if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else if (steady) begin
                m_tready <= 1'b1;
            end else begin
                r = $urandom_range(99);
                if (r < 12) begin
                    m_tready   <= 1'b0;
                    stall_left = ((r < 1) ? $urandom_range(50, 15) : $urandom_range(3, 1)) - 1;
                end else begin
                    m_tready <= 1'b1;
                end
            end
        end
    end

    // Run limit.
    initial begin
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        $display("FAILURE");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        if (steady)
            return 0;
        r = $urandom_range(99);
        if (r < 65)
            return 0;
        if (r < 94)
            return $urandom_range(3, 1);
        return $urandom_range(40, 10);
    endfunction

    function automatic logic [RAW_W-1:0] clamp_raw(longint v);
        if (v < 0)
            return '0;
        if (v > longint'(RAW_MAX))
            return RAW_MAX;
        return v[RAW_W-1:0];
    endfunction

    // Raw temperature close to the reference point C5*256.
    function automatic logic [RAW_W-1:0] d2_near_ref(int spread);
        longint base;
        base = longint'(comp.cal[4]) * 256;
        return clamp_raw(base + longint'($urandom_range(2 * spread)) - spread);
    endfunction

    // Raw temperature nearest the reference point whose first-order deviation from the
    // reference truncates to dev hundredths of a degree.
    function automatic logic [RAW_W-1:0] d2_for_dev(int dev);
        longint base, c6, mag;
        base = longint'(comp.cal[4]) * 256;
        c6   = longint'(comp.cal[5]);
        if (c6 == 0)
            return clamp_raw(base);
        mag = ((dev < 0 ? -longint'(dev) : longint'(dev)) * 8388608 + c6 - 1) / c6;
        return clamp_raw(dev < 0 ? base - mag : base + mag);
    endfunction

    // Offers one sample pair and waits for its beat to be accepted.
    task automatic send_sample(logic [RAW_W-1:0] d1, logic [RAW_W-1:0] d2);
        int gap;
        s_tvalid <= 1'b1;
        s_tdata  <= {d2, d1};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        comp.note_sample(d1, d2);
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // Stops offering and waits until every pending reading has come out.
    task automatic wait_for_drain();
        s_tvalid <= 1'b0;
        while (comp.expected_q.size() != 0) @(posedge aclk);
        repeat (NUM_STAGES + 2) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [COEF_W-1:0] val);
        cfg_wr_en    <= 1'b1;
        cfg_wr_index <= idx;
        cfg_wr_data  <= val;
        @(posedge aclk);
        comp.write_reg(idx, val);
    endtask

    // Loads a full calibration set; the model word carries random upper bits,
    // and the unused index gets a random write as well.
    task automatic load_setting(logic [COEF_W-1:0] c1, logic [COEF_W-1:0] c2,
                                logic [COEF_W-1:0] c3, logic [COEF_W-1:0] c4,
                                logic [COEF_W-1:0] c5, logic [COEF_W-1:0] c6,
                                bit model);
        logic [COEF_W-1:0] mword;
        mword    = 16'($urandom_range(16'hFFFF));
        mword[0] = model;
        write_reg(CFG_IDX_C1, c1);
        write_reg(CFG_IDX_C2, c2);
        write_reg(CFG_IDX_C3, c3);
        write_reg(CFG_IDX_C4, c4);
        write_reg(CFG_IDX_UNUSED, 16'($urandom_range(16'hFFFF)));
        write_reg(CFG_IDX_C5, c5);
        write_reg(CFG_IDX_C6, c6);
        write_reg(CFG_IDX_MODEL, mword);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic load_random_setting();
        load_setting(16'($urandom_range(16'hFFFF)), 16'($urandom_range(16'hFFFF)),
                     16'($urandom_range(16'hFFFF)), 16'($urandom_range(16'hFFFF)),
                     16'($urandom_range(16'hFFFF)), 16'($urandom_range(16'hFFFF)),
                     1'($urandom_range(1)));
    endtask

    // Field extremes and the band edges of the second-order correction.
    task automatic run_directed();
        send_sample('0, '0);
        send_sample(RAW_MAX, RAW_MAX);
        send_sample('0, RAW_MAX);
        send_sample(RAW_MAX, '0);
        send_sample(24'hAAAAAA, 24'h555555);
        send_sample(24'h555555, 24'hAAAAAA);
        // Exactly at the reference temperature, just below it and just above it.
        send_sample(24'($urandom_range(RAW_MAX)), d2_for_dev(0));
        send_sample(24'($urandom_range(RAW_MAX)), d2_for_dev(-1));
        send_sample(24'($urandom_range(RAW_MAX)), d2_for_dev(1));
        // Around the very-low temperature edge.
        send_sample(24'($urandom_range(RAW_MAX)), d2_for_dev(-3599));
        send_sample(24'($urandom_range(RAW_MAX)), d2_for_dev(-3600));
        send_sample(24'($urandom_range(RAW_MAX)), d2_for_dev(-3601));
    endtask

    // Random sample pairs; most temperatures sit near the reference so that
    // every correction band is visited.
    task automatic run_random(int count);
        logic [RAW_W-1:0] d1, d2;
        int r;
        for (int i = 0; i < count; i++) begin
            r = $urandom_range(99);
            if (r < 5)
                d1 = '0;
            else if (r < 10)
                d1 = RAW_MAX;
            else
                d1 = 24'($urandom_range(RAW_MAX));
            r = $urandom_range(99);
            if (r < 30)
                d2 = 24'($urandom_range(RAW_MAX));
            else if (r < 50)
                d2 = d2_near_ref(1 << 12);
            else if (r < 75)
                d2 = d2_near_ref(1 << 18);
            else
                d2 = d2_near_ref(1 << 21);
            send_sample(d1, d2);
        end
    endtask

    // Main sequence.
    initial begin
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Calibration words still at their reset values.
        run_random(30);
        wait_for_drain();

        // Typical 30 bar calibration; the receiver holds off while the sender keeps going.
        load_setting(16'd34982, 16'd36352, 16'd20328, 16'd22354, 16'd26646, 16'd26146, 1'b0);
        run_directed();
        wait_for_drain();
        steady       = 1'b1;
        hold_request = 1'b1;
        run_random(40);
        steady = 1'b0;
        run_random(50);
        wait_for_drain();

        // Typical 2 bar calibration, with a pause until all readings are out.
        load_setting(16'd46372, 16'd43981, 16'd29059, 16'd27842, 16'd31553, 16'd28165, 1'b1);
        run_directed();
        run_random(45);
        wait_for_drain();
        run_random(45);
        wait_for_drain();

        // All-ones calibration, both models.
        load_setting(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
        run_random(70);
        wait_for_drain();
        load_setting(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
        run_random(70);
        wait_for_drain();

        // All-zero calibration written explicitly.
        load_setting('0, '0, '0, '0, '0, '0, 1'b1);
        run_random(30);
        wait_for_drain();

        // Random calibrations; the middle one runs with no idle cycles.
        load_random_setting();
        run_random(60);
        wait_for_drain();
        load_random_setting();
        steady = 1'b1;
        run_random(60);
        steady = 1'b0;
        wait_for_drain();
        load_random_setting();
        run_random(60);
        wait_for_drain();

        if (comp.mismatches == 0 && comp.expected_q.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

FILE: filelist.f
hdl/psc_pkg.sv
hdl/pressure_sensor_compensation.sv
bench/tb.sv
